>>> sv/ogg_page_renumber_crc_core_assert.svh
`ifndef OGG_PAGE_RENUMBER_CRC_CORE_ASSERT_SVH
`define OGG_PAGE_RENUMBER_CRC_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ORPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ORPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/orpc_pkg.sv
package orpc_pkg;

  // Widths
  localparam int unsigned POS_W  = 17;
  localparam int unsigned CRC_W  = 32;
  localparam int unsigned OFFS_W = 32;

  // Page header layout (byte positions within a page)
  localparam logic [POS_W-1:0] POS_SEQ_FIRST = 17'd18;
  localparam logic [POS_W-1:0] POS_CRC_FIRST = 17'd22;
  localparam logic [POS_W-1:0] POS_SEGS      = 17'd26;
  localparam logic [POS_W-1:0] POS_HDR_LEN   = 17'd27;
  localparam logic [POS_W-1:0] POS_CAP_LEN   = 17'd4;
  localparam logic [POS_W-1:0] POS_SEQ_LEN   = 17'd4;

  // Capture pattern "OggS"
  localparam logic [7:0] CAPTURE [4] = '{8'h4f, 8'h67, 8'h67, 8'h53};

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CAPTURE = 2'd1;
  localparam logic [1:0] ERR_TRUNC   = 2'd2;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04c11db7;

  // Depth of the queue between parser and CRC stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              page_end;
    logic [OFFS_W-1:0] page_offset;
    logic              crc_valid;
    logic [CRC_W-1:0]  page_crc;
    logic [1:0]        error_code;
  } res_t;

  // Classified beat handed from the parser to the CRC stage
  typedef struct packed {
    logic [7:0]        out_byte;
    logic              page_end;
    logic [OFFS_W-1:0] page_offset;
    logic              crc_valid;
    logic [1:0]        error_code;
    logic              crc_init;   // restart CRC before this byte
    logic              crc_zero;   // CRC field byte, fed as zero
  } item_t;

  // One byte of the Ogg CRC-32, MSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> sv/orpc_front.sv
module orpc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  orpc_pkg::in_t        in_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  output orpc_pkg::item_t      item_o
);

  logic [31:0]                  shift_q;
  logic [orpc_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [7:0]                   seg_q, seg_d;
  logic [orpc_pkg::POS_W-1:0]   body_q, body_d;
  logic                         carry_q, carry_d;
  logic [31:0]                  stream_q, stream_d;
  logic [31:0]                  start_q, start_d;
  logic [1:0]                   err_q, err_d;

  logic [7:0]                   b;
  logic [7:0]                   ob;
  logic [1:0]                   k;
  logic [31:0]                  shifted;
  logic [8:0]                   sum;
  logic                         carry_in;
  logic                         pend;
  logic [orpc_pkg::POS_W:0]     hdr_end, tot_len, pos_inc, body_lim;

  assign b = in_i.data_byte;

  // Parse one byte against the page state
  always_comb begin
    pos_d    = pos_q;
    seg_d    = seg_q;
    body_d   = body_q;
    carry_d  = carry_q;
    start_d  = start_q;
    err_d    = err_q;
    ob       = b;
    pend     = 1'b0;
    k        = 2'(pos_q - orpc_pkg::POS_SEQ_FIRST);
    shifted  = shift_q >> {k, 3'b000};
    carry_in = (pos_q == orpc_pkg::POS_SEQ_FIRST) ? 1'b0 : carry_q;
    sum      = 9'(b) + 9'(shifted[7:0]) + 9'(carry_in);
    body_lim = (orpc_pkg::POS_W+1)'(orpc_pkg::POS_SEGS) + (orpc_pkg::POS_W+1)'(seg_q);
    hdr_end  = '0;
    tot_len  = '0;
    pos_inc  = (orpc_pkg::POS_W+1)'(pos_q) + 1'b1;

    if (err_q == orpc_pkg::ERR_NONE) begin
      if (pos_q == '0) begin
        start_d = stream_q;
      end
      if (pos_q < orpc_pkg::POS_CAP_LEN && b != orpc_pkg::CAPTURE[pos_q[1:0]]) begin
        err_d = orpc_pkg::ERR_CAPTURE;
      end
    end

    if (err_d == orpc_pkg::ERR_NONE) begin
      // sequence number rewrite, carry ripples byte to byte
      if (shift_q != '0 && pos_q >= orpc_pkg::POS_SEQ_FIRST &&
          pos_q < orpc_pkg::POS_SEQ_FIRST + orpc_pkg::POS_SEQ_LEN) begin
        ob      = sum[7:0];
        carry_d = sum[8];
      end

      // segment table
      if (pos_q == orpc_pkg::POS_SEGS) begin
        seg_d  = b;
        body_d = '0;
      end else if (pos_q > orpc_pkg::POS_SEGS &&
                   (orpc_pkg::POS_W+1)'(pos_q) <= body_lim) begin
        body_d = body_q + orpc_pkg::POS_W'(b);
      end

      // page end check
      hdr_end = (orpc_pkg::POS_W+1)'(orpc_pkg::POS_SEGS) + (orpc_pkg::POS_W+1)'(seg_d);
      tot_len = (orpc_pkg::POS_W+1)'(orpc_pkg::POS_HDR_LEN) + (orpc_pkg::POS_W+1)'(seg_d)
              + (orpc_pkg::POS_W+1)'(body_d);
      pend    = ((orpc_pkg::POS_W+1)'(pos_q) >= hdr_end) && (pos_inc == tot_len);
      pos_d   = pend ? '0 : pos_inc[orpc_pkg::POS_W-1:0];

      if (in_i.stream_end && !pend) begin
        err_d = orpc_pkg::ERR_TRUNC;
      end
    end

    stream_d = stream_q + 32'd1;
  end

  // Classified beat for the CRC stage
  always_comb begin
    item_o.out_byte    = ob;
    item_o.page_end    = pend;
    item_o.page_offset = start_d;
    item_o.crc_valid   = pend && (shift_q != '0);
    item_o.error_code  = err_d;
    item_o.crc_init    = (err_q == orpc_pkg::ERR_NONE) && (pos_q == '0);
    item_o.crc_zero    = (pos_q >= orpc_pkg::POS_CRC_FIRST) &&
                         (pos_q < orpc_pkg::POS_CRC_FIRST + orpc_pkg::POS_SEQ_LEN);
  end

  // Shift register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  // Page state; the last beat of a stream clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      seg_q    <= '0;
      body_q   <= '0;
      carry_q  <= 1'b0;
      stream_q <= '0;
      start_q  <= '0;
      err_q    <= orpc_pkg::ERR_NONE;
    end else if (accept_i) begin
      if (in_i.stream_end) begin
        pos_q    <= '0;
        seg_q    <= '0;
        body_q   <= '0;
        carry_q  <= 1'b0;
        stream_q <= '0;
        start_q  <= '0;
        err_q    <= orpc_pkg::ERR_NONE;
      end else begin
        pos_q    <= pos_d;
        seg_q    <= seg_d;
        body_q   <= body_d;
        carry_q  <= carry_d;
        stream_q <= stream_d;
        start_q  <= start_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

>>> sv/orpc_fifo.sv
module orpc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  orpc_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output orpc_pkg::item_t rdata_o,
  output logic            empty_o
);

  orpc_pkg::item_t               slot_q [orpc_pkg::QUEUE_DEPTH];
  logic [orpc_pkg::QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [orpc_pkg::QUEUE_AW:0]   cnt_q;
  logic                          do_wr, do_rd;

  assign full_o  = (cnt_q == (orpc_pkg::QUEUE_AW+1)'(orpc_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> sv/orpc_back.sv
module orpc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_vld_i,
  input  orpc_pkg::item_t item_i,
  output logic            item_rd_o,
  output orpc_pkg::res_t  res_o,
  output logic            empty_o,
  input  logic            pop_i
);

  logic [orpc_pkg::CRC_W-1:0] crc_q, crc_base, crc_new;
  logic [7:0]                 crc_in;
  orpc_pkg::res_t             res_q;
  logic                       res_vld_q;
  logic                       take;

  // Take a beat when the result register is free or drains this cycle
  assign take      = item_vld_i && (!res_vld_q || pop_i);
  assign item_rd_o = take;

  // Running page CRC
  assign crc_base = item_i.crc_init ? '0 : crc_q;
  assign crc_in   = item_i.crc_zero ? 8'h00 : item_i.out_byte;
  assign crc_new  = orpc_pkg::crc_byte(crc_base, crc_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else if (take) begin
      crc_q <= crc_new;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.out_byte    <= item_i.out_byte;
      res_q.page_end    <= item_i.page_end;
      res_q.page_offset <= item_i.page_offset;
      res_q.crc_valid   <= item_i.crc_valid;
      res_q.page_crc    <= item_i.crc_valid ? crc_new : '0;
      res_q.error_code  <= item_i.error_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (take) begin
      res_vld_q <= 1'b1;
    end else if (pop_i) begin
      res_vld_q <= 1'b0;
    end
  end

  assign res_o   = res_q;
  assign empty_o = !res_vld_q;

endmodule

>>> sv/ogg_page_renumber_crc_core.sv
// Path: a pushed byte is registered in the queue, then in the CRC stage's result register, and shows on res_o.
// Throughput: one byte per cycle; the parser, a four-beat queue and the CRC
// stage with its result register each stall on their own.
// Reset (rst_ni low, asynchronous): shift register, page state, CRC and
// queue are cleared; the block comes out empty and ready.
module ogg_page_renumber_crc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  orpc_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output orpc_pkg::res_t res_o,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i
);

  orpc_pkg::item_t front_item, queue_item;
  logic            accept;
  logic            queue_empty;
  logic            queue_rd;

  assign accept = push && !full;

  // Parser and classifier
  orpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_o      (front_item)
  );

  // Queue between parser and CRC stage
  orpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_i    (queue_rd),
    .rdata_o (queue_item),
    .empty_o (queue_empty)
  );

  // CRC stage and result register
  orpc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (!queue_empty),
    .item_i     (queue_item),
    .item_rd_o  (queue_rd),
    .res_o      (res_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule

>>> sv/orpc_checker.sv
`include "ogg_page_renumber_crc_core_assert.svh"

module orpc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty,
  input logic           pop,
  input orpc_pkg::res_t res_o
);

  // A patch only comes with a page end
  `ORPC_ASSERT_NOW(a_crc_on_end, (!empty && res_o.crc_valid), res_o.page_end, "crc_valid without page_end")

  // A completed page never carries an error
  `ORPC_ASSERT_NOW(a_end_no_err, (!empty && res_o.page_end), (res_o.error_code == orpc_pkg::ERR_NONE), "page_end with error")

  // No patch, no CRC value
  `ORPC_ASSERT_NOW(a_crc_zero, (!empty && !res_o.crc_valid), (res_o.page_crc == '0), "page_crc set without crc_valid")

  // A waiting result holds until taken
  `ORPC_ASSERT_NEXT(a_res_hold, (!empty && !pop), (!empty && $stable(res_o)), "result changed while stalled")

endmodule

bind ogg_page_renumber_crc_core orpc_checker u_orpc_checker (.*);

>>> tb/ogg_page_renumber_crc_checker.sv
module ogg_page_renumber_crc_checker
  import orpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_t         beat_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  res_t        res_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          backlog_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the block's register and page state
  logic [31:0]      seq_shift;
  logic [POS_W-1:0] page_pos;
  logic [7:0]       seg_cnt;
  logic [POS_W-1:0] lace_total;
  logic [31:0]      crc_acc;
  logic             seq_carry;
  logic [31:0]      stream_pos;
  logic [31:0]      page_start;
  logic [1:0]       err_latch;

  res_t rewritten_q [$];
  int   fails = 0;

  // Ogg CRC-32, MSB first, one byte
  function automatic logic [31:0] ogg_crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {b, 24'h0};
    repeat (8) r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic void clear_stream_state();
    page_pos   = '0;
    seg_cnt    = '0;
    lace_total = '0;
    crc_acc    = '0;
    seq_carry  = 1'b0;
    stream_pos = '0;
    page_start = '0;
    err_latch  = ERR_NONE;
  endfunction

  // Advance the page parser by one byte and return the beat it must emit
  function automatic res_t renumber_byte(in_t beat);
    res_t             r;
    logic [POS_W-1:0] pos;
    logic [7:0]       ob;
    logic [1:0]       k;
    logic [8:0]       sum;
    logic             pend;
    int unsigned      p32, seg32, body32;
    pos  = page_pos;
    ob   = beat.data_byte;
    pend = 1'b0;
    r    = '0;
    // Page start and capture pattern
    if (err_latch == ERR_NONE) begin
      if (pos == 0) begin
        page_start = stream_pos;
        crc_acc    = '0;
      end
      if (pos < POS_CAP_LEN && beat.data_byte != CAPTURE[pos[1:0]]) err_latch = ERR_CAPTURE;
    end
    if (err_latch == ERR_NONE) begin
      // Sequence number add, carry rippling from byte 18 upward
      if (seq_shift != 0 && pos >= POS_SEQ_FIRST && pos < POS_SEQ_FIRST + POS_SEQ_LEN) begin
        k         = 2'(pos - POS_SEQ_FIRST);
        sum       = 9'(beat.data_byte) + 9'(seq_shift[8*k +: 8])
                    + 9'((pos == POS_SEQ_FIRST) ? 1'b0 : seq_carry);
        ob        = sum[7:0];
        seq_carry = sum[8];
      end
      // CRC field itself counts as zeros
      if (pos >= POS_CRC_FIRST && pos < POS_CRC_FIRST + 4) crc_acc = ogg_crc_step(crc_acc, 8'h00);
      else crc_acc = ogg_crc_step(crc_acc, ob);
      // Segment table
      if (pos == POS_SEGS) begin
        seg_cnt    = beat.data_byte;
        lace_total = '0;
      end else if (pos > POS_SEGS && pos <= POS_SEGS + seg_cnt) begin
        lace_total = lace_total + POS_W'(beat.data_byte);
      end
      p32    = 32'(pos);
      seg32  = 32'(seg_cnt);
      body32 = 32'(lace_total);
      if (p32 >= POS_SEGS + seg32 && p32 + 1 == POS_HDR_LEN + seg32 + body32) begin
        pend = 1'b1;
        if (seq_shift != 0) begin
          r.crc_valid = 1'b1;
          r.page_crc  = crc_acc;
        end
        page_pos = '0;
      end else begin
        page_pos = pos + 1'b1;
      end
      if (beat.stream_end && !pend) err_latch = ERR_TRUNC;
    end
    r.out_byte    = ob;
    r.page_end    = pend;
    r.page_offset = page_start;
    r.error_code  = err_latch;
    stream_pos    = stream_pos + 32'd1;
    if (beat.stream_end) clear_stream_state();
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      fails++;
    end
  endfunction

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      seq_shift = '0;
      clear_stream_state();
      rewritten_q.delete();
      mismatches_o <= fails;
      backlog_o    <= 0;
    end else begin
      if (cfg_we_i) seq_shift = cfg_wdata_i;
      if (push_i && !full_i) rewritten_q.insert(rewritten_q.size(), renumber_byte(beat_i));
      if (pop_i && !empty_i) begin
        if (rewritten_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %h", $time, res_i);
          fails++;
        end else begin
          want = rewritten_q.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(res_i.out_byte));
          check_field("page_end", 32'(want.page_end), 32'(res_i.page_end));
          check_field("page_offset", want.page_offset, res_i.page_offset);
          check_field("crc_valid", 32'(want.crc_valid), 32'(res_i.crc_valid));
          check_field("page_crc", want.page_crc, res_i.page_crc);
          check_field("error_code", 32'(want.error_code), 32'(res_i.error_code));
        end
      end
      mismatches_o <= fails;
      backlog_o    <= rewritten_q.size();
    end
  end

endmodule

>>> tb/ogg_page_renumber_crc_core_test.sv
module ogg_page_renumber_crc_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import orpc_pkg::*;

  typedef enum logic [1:0] {FLAW_NONE, FLAW_CAPTURE, FLAW_CUT} page_flaw_e;

  localparam int PHASE_BYTES = 228;
  localparam int STALL_LIMIT = 2000;
  localparam logic [31:0] SHIFT_PLAN [8] = '{
    32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
    32'h0000_0000, 32'h00ff_ff01, 32'h0000_0000, 32'h0000_0000
  };

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_t         in_beat;
  logic        empty;
  logic        pop = 1'b0;
  res_t        res;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        steady;
  int          mismatches;
  int          backlog;
  int          byte_count = 0;
  int          stall_cycles = 0;

  ogg_page_renumber_crc_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_i        (in_beat),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  ogg_page_renumber_crc_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .beat_i       (in_beat),
    .empty_i      (empty),
    .pop_i        (pop),
    .res_i        (res),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .backlog_o    (backlog)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure except in the steady stretch
  always @(posedge clk) begin
    pop <= steady || ($urandom_range(99) >= 21);
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One byte beat, with an occasional idle cycle ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!steady && $urandom_range(99) < 21) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_beat <= '{data_byte: b, stream_end: last};
    @(posedge clk);
    while (full) @(posedge clk);
    byte_count++;
  endtask

  // Drain everything in flight, then write the shift register
  task automatic program_shift(input logic [31:0] value);
    push <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Build one Ogg page and send it, optionally broken
  task automatic send_page(input logic [31:0] seq_no, input int nseg, input int lace_hi,
                           input page_flaw_e flaw, input bit close);
    logic [7:0] page [$];
    int         body;
    int         lace;
    int         idx;
    int         cut;
    page = {};
    body = 0;
    for (int i = 0; i < 4; i++) page = {page, CAPTURE[i]};
    page = {page, 8'h00};
    page = {page, 8'($urandom_range(0, 7))};
    repeat (12) page = {page, 8'($urandom)};             // granule, serial
    for (int i = 0; i < 4; i++) page = {page, seq_no[8*i +: 8]};
    repeat (4) page = {page, 8'($urandom)};              // stale CRC, ignored
    page = {page, 8'(nseg)};
    for (int i = 0; i < nseg; i++) begin
      lace = (nseg < 8 && $urandom_range(15) == 0) ? 255 : $urandom_range(0, lace_hi);
      page = {page, 8'(lace)};
      body += lace;
    end
    repeat (body) page = {page, 8'($urandom)};
    if (flaw == FLAW_CAPTURE) begin
      idx       = $urandom_range(3);
      page[idx] = page[idx] ^ 8'($urandom_range(1, 255));
    end
    cut = page.size();
    if (flaw == FLAW_CUT) cut = $urandom_range(1, page.size() - 1);
    for (int i = 0; i < cut; i++) send_byte(page[i], close && (i == cut - 1));
  endtask

  // A stream of pages; a broken page ends the stream early
  task automatic send_stream(input int npages);
    logic [31:0] seq_no;
    page_flaw_e  flaw;
    int          pick;
    int          nseg;
    int          lace_hi;
    int          noise;
    seq_no = ($urandom_range(7) == 0) ? 32'hffff_ffff - $urandom_range(3) : $urandom;
    for (int p = 0; p < npages; p++) begin
      pick = $urandom_range(99);
      flaw = (pick < 8) ? FLAW_CAPTURE : (pick < 16) ? FLAW_CUT : FLAW_NONE;
      if ($urandom_range(39) == 0) begin
        nseg    = 255;
        lace_hi = 1;
      end else begin
        nseg    = $urandom_range(0, 5);
        lace_hi = 24;
      end
      if (flaw == FLAW_CAPTURE) begin
        noise = $urandom_range(0, 6);
        send_page(seq_no, nseg, lace_hi, flaw, noise == 0);
        for (int j = 0; j < noise; j++) send_byte(8'($urandom), j == noise - 1);
        return;
      end
      send_page(seq_no, nseg, lace_hi, flaw, (flaw == FLAW_CUT) || (p == npages - 1));
      if (flaw == FLAW_CUT) return;
      seq_no++;
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    push      = 1'b0;
    in_beat   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    steady    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sequence wrap, one-byte streams, bad pattern then early end
    program_shift(32'h0000_0001);
    send_page(32'hffff_ffff, 0, 0, FLAW_NONE, 1);
    send_byte(8'h00, 1'b1);
    send_byte(CAPTURE[0], 1'b1);
    send_byte(CAPTURE[0], 1'b0);
    send_byte(CAPTURE[1], 1'b0);
    send_byte(CAPTURE[2], 1'b0);
    send_byte(8'hff, 1'b1);
    send_page(32'h0000_00ff, 255, 0, FLAW_NONE, 1);

    // Random streams across several shift settings
    for (int ph = 0; ph < 8; ph++) begin
      program_shift((ph == 6) ? $urandom : SHIFT_PLAN[ph]);
      steady <= (ph == 3);
      while (byte_count < 33 + (ph + 1) * PHASE_BYTES) send_stream($urandom_range(1, 4));
    end

    push <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
